/* sv/svf_lowpass_soft_clip_core_assert.svh */
// Assertion macros used by the filter core RTL.
`ifndef SVF_LOWPASS_SOFT_CLIP_CORE_ASSERT_SVH
`define SVF_LOWPASS_SOFT_CLIP_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SVFLPSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SVFLPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/svflpsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package svflpsc_pkg;

    localparam int SVFLPSC_STATE_FRAC_BITS = 8;
    localparam logic [13:0] ALPHA_Q16 = 14'd13107;
    localparam int CLIP_BITS = 15;
    localparam int DIV_STEPS = 15;
    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef logic [3:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_MUL_DCUT,
        OP_UPD_CUT,
        OP_MUL_DRES,
        OP_UPD_RES,
        OP_MUL_QB,
        OP_CALC_HP,
        OP_MUL_FH,
        OP_UPD_BAND,
        OP_MUL_FB,
        OP_UPD_LOW,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_LOOP,
        JMP_WAIT_OUT,
        JMP_GOTO
    } jmp_t;

    typedef struct packed {
        op_t  op;
        jmp_t jmp;
        pc_t  target;
    } ctrl_t;

    localparam pc_t PC_START    = 4'd0;
    localparam pc_t PC_DIV_LOOP = 4'd12;
    localparam pc_t PC_FINISH   = 4'd13;

    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t w;
        case (pc)
            4'd0:
            begin
                w = '{op: OP_IDLE, jmp: JMP_WAIT_IN, target: PC_START};
            end
            4'd1:
            begin
                w = '{op: OP_MUL_DCUT, jmp: JMP_NEXT, target: PC_START};
            end
            4'd2:
            begin
                w = '{op: OP_UPD_CUT, jmp: JMP_NEXT, target: PC_START};
            end
            4'd3:
            begin
                w = '{op: OP_MUL_DRES, jmp: JMP_NEXT, target: PC_START};
            end
            4'd4:
            begin
                w = '{op: OP_UPD_RES, jmp: JMP_NEXT, target: PC_START};
            end
            4'd5:
            begin
                w = '{op: OP_MUL_QB, jmp: JMP_NEXT, target: PC_START};
            end
            4'd6:
            begin
                w = '{op: OP_CALC_HP, jmp: JMP_NEXT, target: PC_START};
            end
            4'd7:
            begin
                w = '{op: OP_MUL_FH, jmp: JMP_NEXT, target: PC_START};
            end
            4'd8:
            begin
                w = '{op: OP_UPD_BAND, jmp: JMP_NEXT, target: PC_START};
            end
            4'd9:
            begin
                w = '{op: OP_MUL_FB, jmp: JMP_NEXT, target: PC_START};
            end
            4'd10:
            begin
                w = '{op: OP_UPD_LOW, jmp: JMP_NEXT, target: PC_START};
            end
            4'd11:
            begin
                w = '{op: OP_DIV_INIT, jmp: JMP_NEXT, target: PC_START};
            end
            4'd12:
            begin
                w = '{op: OP_DIV_STEP, jmp: JMP_LOOP, target: PC_START};
            end
            4'd13:
            begin
                w = '{op: OP_FINISH, jmp: JMP_WAIT_OUT, target: PC_START};
            end
            default:
            begin
                w = '{op: OP_NOP, jmp: JMP_GOTO, target: PC_START};
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/svf_lowpass_soft_clip_core.sv */
// The core takes one word at a time: in_stall stays high from the accepted input
// until the finish step hands the result on, and the restoring divider of the
// soft clip dominates the work on each word.
// Reset clears the filter and smoothing state, the step counter and out_valid;
// in_stall is low right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "svf_lowpass_soft_clip_core_assert.svh"

module svf_lowpass_soft_clip_core
    import svflpsc_pkg::*;
#(
    parameter int STATE_FRAC_BITS = SVFLPSC_STATE_FRAC_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [20:0] mixed_sum,
    input  wire logic        [15:0] target_cutoff,
    input  wire logic        [15:0] target_resonance,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed      [15:0] audio_out
);

    pc_t                pc_reg, pc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] audio_out_reg;
    ctrl_t              ctrl;
    logic               in_fire;
    logic               out_free;
    logic               emit;
    logic signed [15:0] y;

    always_comb
    begin
        ctrl     = ucode_rom(pc_reg);
        in_stall = (ctrl.jmp != JMP_WAIT_IN);
        in_fire  = in_valid && !in_stall;
        out_free = !out_valid_reg || !out_stall;
        emit     = (ctrl.op == OP_FINISH) && out_free;
    end

    always_comb
    begin
        pc_next = pc_reg;
        case (ctrl.jmp)
            JMP_NEXT:
            begin
                pc_next = pc_reg + 4'd1;
            end
            JMP_WAIT_IN:
            begin
                pc_next = in_fire ? pc_reg + 4'd1 : pc_reg;
            end
            JMP_LOOP:
            begin
                pc_next = (cnt_reg != '0) ? pc_reg : pc_reg + 4'd1;
            end
            JMP_WAIT_OUT:
            begin
                pc_next = out_free ? ctrl.target : pc_reg;
            end
            JMP_GOTO:
            begin
                pc_next = ctrl.target;
            end
            default:
            begin
                pc_next = PC_START;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.op == OP_DIV_INIT)
        begin
            cnt_next = CNT_W'(DIV_STEPS - 1);
        end
        else if (ctrl.op == OP_DIV_STEP && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_START;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            audio_out_reg <= y;
        end
    end

    svflpsc_datapath #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .load             (in_fire),
        .mixed_sum        (mixed_sum),
        .target_cutoff    (target_cutoff),
        .target_resonance (target_resonance),
        .y                (y)
    );

    assign out_valid = out_valid_reg;
    assign audio_out = audio_out_reg;

    `SVFLPSC_ASSERT_NEXT(a_one_word_at_a_time, in_fire, in_stall,
        "input taken again while a word is in work")
    `SVFLPSC_ASSERT_NOW(a_out_from_finish, $rose(out_valid_reg),
        $past(ctrl.op == OP_FINISH), "result raised outside the finish step")
    `SVFLPSC_ASSERT_NEXT(a_div_loop_holds, ctrl.op == OP_DIV_STEP && cnt_reg != '0,
        pc_reg == PC_DIV_LOOP, "divider loop left early")
    `SVFLPSC_ASSERT_NEXT(a_finish_waits, ctrl.op == OP_FINISH && !out_free,
        pc_reg == PC_FINISH && out_valid_reg, "finish step dropped a blocked result")

endmodule

`default_nettype wire

/* sv/svflpsc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module svflpsc_datapath
    import svflpsc_pkg::*;
#(
    parameter int STATE_FRAC_BITS = SVFLPSC_STATE_FRAC_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctrl,
    input  wire logic               load,
    input  wire logic signed [20:0] mixed_sum,
    input  wire logic        [15:0] target_cutoff,
    input  wire logic        [15:0] target_resonance,
    output logic signed      [15:0] y
);

    logic signed [15:0] mix_reg;
    logic        [15:0] tf_reg;
    logic        [15:0] tq_reg;
    logic        [15:0] cut_reg, cut_next;
    logic        [15:0] res_reg, res_next;
    logic signed [31:0] low_reg, low_next;
    logic signed [31:0] band_reg, band_next;
    logic signed [31:0] hp_reg;
    logic signed [48:0] prod_reg;
    logic        [32:0] rem_reg;
    logic        [32:0] den_reg;
    logic        [CLIP_BITS-1:0] quot_reg;
    logic               neg_reg;

    logic signed [15:0] mix_clamp;
    logic signed [16:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [15:0] smooth_s;
    logic        [15:0] smooth_r;
    logic signed [49:0] hp_full;
    logic signed [49:0] acc_full;
    logic        [31:0] abs_low;
    logic        [33:0] rem_sh;
    logic               rem_ge;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] smooth_upd(input logic [15:0] s,
                                               input logic signed [48:0] p);
        logic signed [32:0] rnd;
        logic signed [16:0] stp;
        logic signed [17:0] sum;
        logic        [15:0] r;
        rnd = $signed(p[32:0]) + 33'sd32768;
        stp = 17'(rnd >>> 16);
        sum = $signed({2'b00, s}) + 18'(stp);
        if (sum < 18'sd0)
        begin
            r = 16'd0;
        end
        else if (sum > 18'sd65535)
        begin
            r = 16'hffff;
        end
        else
        begin
            r = sum[15:0];
        end
        return r;
    endfunction

    always_comb
    begin
        if (mixed_sum < -21'sd32768)
        begin
            mix_clamp = -16'sd32768;
        end
        else if (mixed_sum > 21'sd32767)
        begin
            mix_clamp = 16'sd32767;
        end
        else
        begin
            mix_clamp = mixed_sum[15:0];
        end
    end

    always_comb
    begin
        mul_a = $signed({1'b0, cut_reg});
        mul_b = band_reg;
        case (ctrl.op)
            OP_MUL_DCUT:
            begin
                mul_a = $signed({1'b0, tf_reg}) - $signed({1'b0, cut_reg});
                mul_b = $signed({18'd0, ALPHA_Q16});
            end
            OP_MUL_DRES:
            begin
                mul_a = $signed({1'b0, tq_reg}) - $signed({1'b0, res_reg});
                mul_b = $signed({18'd0, ALPHA_Q16});
            end
            OP_MUL_QB:
            begin
                mul_a = $signed({1'b0, res_reg});
                mul_b = band_reg;
            end
            OP_MUL_FH:
            begin
                mul_a = $signed({1'b0, cut_reg});
                mul_b = hp_reg;
            end
            default:
            begin
                mul_a = $signed({1'b0, cut_reg});
                mul_b = band_reg;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign smooth_s = (ctrl.op == OP_UPD_CUT) ? $signed(cut_reg) : $signed(res_reg);
    assign smooth_r = smooth_upd(smooth_s, prod_reg);
    assign hp_full  = (50'(mix_reg) <<< STATE_FRAC_BITS) - 50'(low_reg)
                    - 50'(prod_reg >>> 16);
    assign acc_full = ((ctrl.op == OP_UPD_BAND) ? 50'(band_reg) : 50'(low_reg))
                    + 50'(prod_reg >>> 15);
    assign abs_low  = low_reg[31] ? (~low_reg + 32'd1) : low_reg;
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        cut_next  = cut_reg;
        res_next  = res_reg;
        band_next = band_reg;
        low_next  = low_reg;
        case (ctrl.op)
            OP_UPD_CUT:
            begin
                cut_next = smooth_r;
            end
            OP_UPD_RES:
            begin
                res_next = smooth_r;
            end
            OP_UPD_BAND:
            begin
                band_next = sat32(acc_full);
            end
            OP_UPD_LOW:
            begin
                low_next = sat32(acc_full);
            end
            default:
            begin
                cut_next = cut_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_reg  <= '0;
            res_reg  <= '0;
            band_reg <= '0;
            low_reg  <= '0;
        end
        else
        begin
            cut_reg  <= cut_next;
            res_reg  <= res_next;
            band_reg <= band_next;
            low_reg  <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mix_reg <= mix_clamp;
            tf_reg  <= target_cutoff;
            tq_reg  <= target_resonance;
        end
        if (ctrl.op == OP_MUL_DCUT || ctrl.op == OP_MUL_DRES || ctrl.op == OP_MUL_QB
            || ctrl.op == OP_MUL_FH || ctrl.op == OP_MUL_FB)
        begin
            prod_reg <= mul_p;
        end
        if (ctrl.op == OP_CALC_HP)
        begin
            hp_reg <= sat32(hp_full);
        end
        if (ctrl.op == OP_DIV_INIT)
        begin
            rem_reg  <= {1'b0, abs_low};
            den_reg  <= (33'd1 << (CLIP_BITS + STATE_FRAC_BITS)) + {1'b0, abs_low};
            quot_reg <= '0;
            neg_reg  <= low_reg[31];
        end
        if (ctrl.op == OP_DIV_STEP)
        begin
            rem_reg  <= rem_ge ? 33'(rem_sh - {1'b0, den_reg}) : rem_sh[32:0];
            quot_reg <= {quot_reg[CLIP_BITS-2:0], rem_ge};
        end
    end

    assign y = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});

endmodule

`default_nettype wire
